>>> rtl/vsl_pkg.sv
// Package for the velocity smoothing and limiting unit.
// Holds register indexes, widths and the sequencer state type; no dependencies.
package vsl_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned LimW  = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegSmooth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAlpha  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxLin = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaxAng = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StClamp,
    StMag,
    StDivInit,
    StDiv,
    StSqrtInit,
    StSqrt,
    StNext,
    StOut
  } state_e;

endpackage

>>> rtl/vsl_divsqrt.sv
// Shared iterative unit: restoring divide (64/32 bits, one quotient bit per cycle)
// or integer square root (two radicand bits per cycle). Uses vsl_pkg.
module vsl_divsqrt import vsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, acc_q, acc_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, sqrt_q, sqrt_d, done_q, done_d;
  logic [64:0] trial;
  logic [65:0] strial;
  logic [65:0] sacc;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    acc_d  = acc_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    done_d = 1'b0;
    trial  = '0;
    sacc   = '0;
    strial = '0;
    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      den_d  = den_i;
      quo_d  = num_i;
      rem_d  = '0;
      acc_d  = '0;
      cnt_d  = sqrt_i ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (!sqrt_q) begin
        trial = {rem_q, quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
        if (trial >= {33'd0, den_q}) begin
          rem_d = 64'(trial - {33'd0, den_q});
          quo_d[0] = 1'b1;
        end else begin
          rem_d = trial[63:0];
        end
      end else begin
        sacc   = {rem_q, quo_q[63:62]};
        strial = {acc_q, 2'b01};
        quo_d  = {quo_q[61:0], 2'b00};
        if (sacc >= strial) begin
          rem_d = 64'(sacc - strial);
          acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = sacc[63:0];
          acc_d = {acc_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    acc_q <= acc_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = sqrt_q ? acc_q : quo_q;

endmodule

>>> rtl/velocity_smooth_and_limit_unit.sv
// Velocity smoothing and limiting unit: EMA filter, per-axis clamp and vector
// magnitude clamp. Uses vsl_pkg and the shared divide/square-root unit vsl_divsqrt.
//
// One transaction in gives one transaction out. When the planar speed after the per-axis
// clamps is within the linear limit, the magnitude clamp is skipped. When the magnitude
// clamp runs, each of x and y needs one 64-step divide and one 32-step square root on
// the single shared unit. The block is not ready while an item is in progress; a result
// still held by the receiver stalls the block only once the next result is ready to be
// presented.
module velocity_smooth_and_limit_unit import vsl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: vel_x[15:0], vel_y[31:16], vel_omega[47:32].
  input  logic [47:0]         s_axis_tdata,
  // tuser: clear_history.
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: out_x[15:0], out_y[31:16], out_omega[47:32].
  output logic [47:0]         m_axis_tdata,
  // tuser: was_limited.
  output logic                m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic smooth_q;
  logic [8:0] alpha_q;
  logic [LimW-1:0] lin_q, ang_q;
  logic [29:0] lin2_q;
  logic signed [DataW-1:0] hx_q, hy_q, hw_q;
  logic hvalid_q, hvalid_d;
  logic signed [DataW-1:0] x_q, y_q, w_q, x_d, y_d, w_d;
  logic hit_q, hit_d, axis_q, axis_d;
  logic [63:0] s_q, s_d, tmp_q, tmp_d;
  logic [47:0] odata_q;
  logic ouser_q, ovalid_q;
  logic div_go_q, sqrt_go_q;
  logic du_done;
  logic [63:0] du_res;
  logic signed [DataW-1:0] bl_x, bl_y, bl_w;
  logic [8:0] a_sat;
  logic signed [16:0] lin_s, ang_s;
  logic [15:0] ax, ay, mag;
  logic in_fire, out_load;

  function automatic logic signed [15:0] blend(input logic signed [15:0] now,
      input logic signed [15:0] old, input logic [8:0] a);
    logic signed [27:0] sum;
    sum = $signed({1'b0, a}) * now + $signed(10'd256 - {1'b0, a}) * old + 28'sd128;
    return sum[23:8];
  endfunction

  function automatic logic signed [15:0] clampf(input logic signed [15:0] v,
      input logic signed [16:0] lim);
    if ($signed({v[15], v}) > lim) return lim[15:0];
    if ($signed({v[15], v}) < -lim) return 16'(-lim);
    return v;
  endfunction

  assign a_sat = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
  assign bl_x  = blend($signed(s_axis_tdata[15:0]), hx_q, a_sat);
  assign bl_y  = blend($signed(s_axis_tdata[31:16]), hy_q, a_sat);
  assign bl_w  = blend($signed(s_axis_tdata[47:32]), hw_q, a_sat);
  assign lin_s = $signed({2'b00, lin_q});
  assign ang_s = $signed({2'b00, ang_q});
  assign ax    = x_q[15] ? 16'(-x_q) : x_q;
  assign ay    = y_q[15] ? 16'(-y_q) : y_q;
  assign mag   = axis_q ? ay : ax;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StOut) && (!ovalid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (in_fire) state_d = StClamp;
      StClamp:    state_d = StMag;
      StMag:      state_d = StCheck;
      StCheck:    state_d = (s_q > {34'd0, lin2_q}) ? StDivInit : StOut;
      StDivInit:  state_d = StDiv;
      StDiv:      if (du_done) state_d = StSqrtInit;
      StSqrtInit: state_d = StSqrt;
      StSqrt:     if (du_done) state_d = StNext;
      StNext:     state_d = axis_q ? StOut : StCheck;
      StOut:      if (out_load) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    x_d = x_q; y_d = y_q; w_d = w_q; hit_d = hit_q; axis_d = axis_q;
    s_d = s_q; tmp_d = tmp_q; hvalid_d = hvalid_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          x_d = $signed(s_axis_tdata[15:0]);
          y_d = $signed(s_axis_tdata[31:16]);
          w_d = $signed(s_axis_tdata[47:32]);
          hit_d = 1'b0;
          axis_d = 1'b0;
          if (s_axis_tuser) hvalid_d = 1'b0;
          if (smooth_q) begin
            if (hvalid_q && !s_axis_tuser) begin
              x_d = bl_x; y_d = bl_y; w_d = bl_w;
            end
            hvalid_d = 1'b1;
          end
        end
      end
      StClamp: begin
        x_d = clampf(x_q, lin_s);
        y_d = clampf(y_q, lin_s);
        w_d = clampf(w_q, ang_s);
        if (x_d != x_q || y_d != y_q || w_d != w_q) hit_d = 1'b1;
      end
      StMag: s_d = {32'd0, ({16'd0, ax} * {16'd0, ax}) + ({16'd0, ay} * {16'd0, ay})};
      StCheck: tmp_d = {32'd0, {16'd0, mag} * {16'd0, mag}};
      StDivInit: tmp_d = {32'd0, tmp_q[31:0]} * {34'd0, lin2_q};
      StSqrtInit: tmp_d = du_res;
      StNext: begin
        if (axis_q) y_d = y_q[15] ? 16'(-du_res[15:0]) : du_res[15:0];
        else x_d = x_q[15] ? 16'(-du_res[15:0]) : du_res[15:0];
        axis_d = 1'b1;
        hit_d = 1'b1;
      end
      default: ;
    endcase
  end

  vsl_divsqrt u_du (
    .clk_i, .rst_ni,
    .start_i(div_go_q || sqrt_go_q),
    .sqrt_i (sqrt_go_q),
    .num_i  (tmp_q),
    .den_i  (s_q[31:0]),
    .done_o (du_done),
    .res_o  (du_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; smooth_q <= 1'b1; alpha_q <= 9'd77;
      lin_q <= 15'd2867; ang_q <= 15'd10240;
      hx_q <= '0; hy_q <= '0; hw_q <= '0; hvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
      div_go_q <= 1'b0; sqrt_go_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hvalid_q <= hvalid_d;
      div_go_q <= (state_q == StDivInit);
      sqrt_go_q <= (state_q == StSqrtInit);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSmooth: smooth_q <= cfg_data_i[0];
          RegAlpha:  alpha_q <= cfg_data_i[8:0];
          RegMaxLin: lin_q <= cfg_data_i[LimW-1:0];
          RegMaxAng: ang_q <= cfg_data_i[LimW-1:0];
          default: ;
        endcase
      end
      if (in_fire && smooth_q) begin
        hx_q <= x_d; hy_q <= y_d; hw_q <= w_d;
      end
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; w_q <= w_d; hit_q <= hit_d; axis_q <= axis_d;
    s_q <= s_d; tmp_q <= tmp_d;
    lin2_q <= {15'd0, lin_q} * {15'd0, lin_q};
    if (out_load) begin
      odata_q <= {w_q, y_q, x_q};
      ouser_q <= hit_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivInit) |-> (s_q > {34'd0, lin2_q})) else $error("needless scaling");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && smooth_q) |=> hvalid_q) else $error("history not marked valid");

endmodule
